### hw/rtl/sppt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the stepper pulse generator and position tracker
// no dependencies

package sppt_pkg;

    // input word kinds carried in tuser
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_PRESET = 2'd2;

    // configuration register indexes (byte address 4 * index)
    localparam logic [1:0] REG_HIGH_TICKS   = 2'd0;
    localparam logic [1:0] REG_PERIOD_TICKS = 2'd1;
    localparam logic [1:0] REG_MID_POSITION = 2'd2;

    localparam logic [15:0] HIGH_TICKS_RST   = 16'd1;
    localparam logic [15:0] PERIOD_TICKS_RST = 16'd2;
    localparam logic [15:0] MID_POSITION_RST = 16'd0;

    // steps needed since the last re-reference before a sensor hit counts
    localparam logic [15:0] REREF_MIN_STEPS = 16'd2000;
    localparam logic [15:0] U16_MAX         = 16'hFFFF;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [15:0] high_ticks;
        logic [15:0] period_ticks;
        logic [15:0] mid_position;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] step_count;
        logic [15:0] target_position;
        logic        forward;
        logic [15:0] preset_value;
        logic        sensor_active;
    } item_t;

    typedef struct packed {
        logic        step_clock;
        logic        moving;
        logic [15:0] position;
        logic        step_done;
    } result_t;

endpackage

### hw/rtl/stepper_pulse_position_tracker_core.sv
`timescale 1ns / 1ps
// top level: input word register, motion core, result register and apb registers
// depends on sppt_pkg, sppt_apb_regs, sppt_motion_core
//
// path: input word register, combinational core, result register that offers the word
// throughput: one word per clock while the result stream is not stalled,
// the state update is a single pass per word
// reset: rst_n clears both stage valids and all motion state, registers take defaults
// a full result register does not block input while the input register can still take one

module stepper_pulse_position_tracker_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // step_count[15:0], target_position[31:16], forward[32], preset_value[48:33],
    // sensor_active[49], zero fill [55:50]
    input  logic [sppt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // action[1:0]
    input  logic [1:0]                       s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // step_clock[0], moving[1], position[17:2], step_done[18], zero fill [23:19]
    output logic [sppt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import sppt_pkg::*;

    cfg_t    cfg;
    item_t   in_word;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    // unpack the input word
    assign in_word.action          = s_axis_tuser;
    assign in_word.step_count      = s_axis_tdata[15:0];
    assign in_word.target_position = s_axis_tdata[31:16];
    assign in_word.forward         = s_axis_tdata[32];
    assign in_word.preset_value    = s_axis_tdata[48:33];
    assign in_word.sensor_active   = s_axis_tdata[49];

    // the held word moves through the core whenever the result register frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= in_word;
    end

    sppt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // motion state commits only when its result is captured
    sppt_motion_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (in_item_reg),
        .commit (advance),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= core_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.step_done, out_reg.position,
                            out_reg.moving, out_reg.step_clock};

    // a word passed to the core always lands in the result register
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not filled after advance");

    // a completed step always leaves the clock low
    a_done_clock_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.step_done) |-> !out_reg.step_clock)
        else $error("step done with step clock high");

    // a held word that cannot advance stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held input word lost or changed");

    // a stalled result word stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word lost or changed");

endmodule

### hw/rtl/sppt_apb_regs.sv
`timescale 1ns / 1ps
// apb configuration registers: high time, period and re-reference position
// depends on sppt_pkg

module sppt_apb_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sppt_pkg::cfg_t     cfg
);
    import sppt_pkg::*;

    logic [15:0] high_ticks_reg;
    logic [15:0] period_ticks_reg;
    logic [15:0] mid_position_reg;
    logic [1:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_ticks_reg   <= HIGH_TICKS_RST;
            period_ticks_reg <= PERIOD_TICKS_RST;
            mid_position_reg <= MID_POSITION_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_HIGH_TICKS:   high_ticks_reg   <= pwdata[15:0];
                REG_PERIOD_TICKS: period_ticks_reg <= pwdata[15:0];
                REG_MID_POSITION: mid_position_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_HIGH_TICKS:   prdata = {16'd0, high_ticks_reg};
            REG_PERIOD_TICKS: prdata = {16'd0, period_ticks_reg};
            REG_MID_POSITION: prdata = {16'd0, mid_position_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.high_ticks   = high_ticks_reg;
    assign cfg.period_ticks = period_ticks_reg;
    assign cfg.mid_position = mid_position_reg;

endmodule

### hw/rtl/sppt_motion_core.sv
`timescale 1ns / 1ps
// motion state registers and the single-pass next-state logic for one word
// depends on sppt_pkg

module sppt_motion_core (
    input  logic              clk,
    input  logic              rst_n,
    input  sppt_pkg::cfg_t    cfg,
    input  sppt_pkg::item_t   item,
    input  logic              commit,
    output sppt_pkg::result_t result
);
    import sppt_pkg::*;

    logic [15:0] phase_reg, phase_next;
    logic [15:0] steps_left_reg, steps_left_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] target_reg, target_next;
    logic        dir_reg, dir_next;
    logic [15:0] since_ref_reg, since_ref_next;
    logic        clock_level_reg, clock_level_next;

    logic [15:0] phase_inc;
    logic [15:0] pos_stepped;
    logic [15:0] since_ref_inc;
    logic        done;

    assign phase_inc     = phase_reg + 16'd1;
    assign since_ref_inc = (since_ref_reg != U16_MAX) ? since_ref_reg + 16'd1 : since_ref_reg;

    always_comb
    begin
        if (dir_reg)
            pos_stepped = (pos_reg != U16_MAX) ? pos_reg + 16'd1 : pos_reg;
        else
            pos_stepped = (pos_reg != 16'd0) ? pos_reg - 16'd1 : pos_reg;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        steps_left_next  = steps_left_reg;
        pos_next         = pos_reg;
        target_next      = target_reg;
        dir_next         = dir_reg;
        since_ref_next   = since_ref_reg;
        clock_level_next = clock_level_reg;
        done             = 1'b0;

        case (item.action)
            ACT_TICK:
            begin
                if (steps_left_reg != 16'd0)
                begin
                    if (phase_inc <= cfg.high_ticks)
                    begin
                        phase_next       = phase_inc;
                        clock_level_next = 1'b1;
                    end
                    else if (phase_inc < cfg.period_ticks)
                    begin
                        phase_next       = phase_inc;
                        clock_level_next = 1'b0;
                    end
                    else
                    begin
                        // end of one step period
                        done             = 1'b1;
                        phase_next       = 16'd0;
                        clock_level_next = 1'b0;
                        steps_left_next  = steps_left_reg - 16'd1;
                        since_ref_next   = since_ref_inc;
                        pos_next         = pos_stepped;
                        if (item.sensor_active && dir_reg && (since_ref_inc > REREF_MIN_STEPS))
                        begin
                            pos_next       = cfg.mid_position;
                            since_ref_next = 16'd0;
                        end
                        if (pos_next == target_reg)
                            steps_left_next = 16'd0;
                    end
                end
            end
            ACT_START:
            begin
                steps_left_next = item.step_count;
                target_next     = item.target_position;
                dir_next        = item.forward;
            end
            ACT_PRESET:
            begin
                pos_next = item.preset_value;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= 16'd0;
            steps_left_reg  <= 16'd0;
            pos_reg         <= 16'd0;
            target_reg      <= 16'd0;
            dir_reg         <= 1'b0;
            since_ref_reg   <= 16'd0;
            clock_level_reg <= 1'b0;
        end
        else if (commit)
        begin
            phase_reg       <= phase_next;
            steps_left_reg  <= steps_left_next;
            pos_reg         <= pos_next;
            target_reg      <= target_next;
            dir_reg         <= dir_next;
            since_ref_reg   <= since_ref_next;
            clock_level_reg <= clock_level_next;
        end
    end

    assign result.step_clock = clock_level_next;
    assign result.moving     = (steps_left_next != 16'd0);
    assign result.position   = pos_next;
    assign result.step_done  = done;

endmodule
